/* rtl/cpg_pkg.sv */
`default_nettype none

package cpg_pkg;

	// Width of every coordinate and colour field on the ports.
	localparam int FIELD_W = 16;

	// Default coordinate width inside the rasterizer.
	localparam int CP_COORD_BITS = 16;

	// Width of the two's complement decision term.
	localparam int DEC_W = 21;

	// Decision term constants of the midpoint walk.
	localparam int DEC_START  = 3;
	localparam int DEC_INC_E  = 6;
	localparam int DEC_INC_SE = 10;

	// Pixels in one symmetry group, and the index of the last one.
	localparam int GROUP_PIX = 8;
	localparam int IDX_W     = $clog2(GROUP_PIX);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(GROUP_PIX - 1);

	// Operation codes of an input item.
	localparam logic OP_START   = 1'b0;
	localparam logic OP_ADVANCE = 1'b1;

	typedef struct packed {
		logic               opcode;
		logic [FIELD_W-1:0] centre_x;
		logic [FIELD_W-1:0] centre_y;
		logic [FIELD_W-1:0] radius;
		logic [FIELD_W-1:0] pixel_colour;
		logic               fill;
	} cpg_in_t;

	typedef struct packed {
		logic [FIELD_W-1:0] out_x;
		logic [FIELD_W-1:0] out_y;
		logic [FIELD_W-1:0] out_colour;
		logic               group_last;
		logic               circle_done;
	} cpg_out_t;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} cpg_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             start;
		logic             advance;
		logic             emit;
		logic [IDX_W-1:0] pix_idx;
	} cpg_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic busy;
		logic out_room;
	} cpg_sts_t;

endpackage

`default_nettype wire

/* rtl/cpg_ctrl.sv */
`default_nettype none

module cpg_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	input  wire logic             req_op,
	output logic                  req_stall,
	input  wire cpg_pkg::cpg_sts_t sts_i,
	output cpg_pkg::cpg_cmd_t     cmd_o
);
	import cpg_pkg::*;

	cpg_state_t       state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic             take_ok;
	logic             take;

	// State and pixel index registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	// Next state and commands. A new item is taken when idle, or in the
	// cycle that hands the last pixel of a group to the output register.
	always_comb begin
		state_d       = state_q;
		idx_d         = idx_q;
		cmd_o.start   = 1'b0;
		cmd_o.advance = 1'b0;
		cmd_o.emit    = 1'b0;
		cmd_o.pix_idx = idx_q;
		take_ok       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				take_ok = 1'b1;
			end
			ST_EMIT: begin
				cmd_o.emit = sts_i.out_room;
				if (sts_i.out_room) begin
					idx_d = idx_q + 1'b1;
					if (idx_q == IDX_LAST) begin
						take_ok = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		take = take_ok && req_valid;
		if (take) begin
			if (req_op == OP_START) begin
				cmd_o.start = 1'b1;
			end else if (sts_i.busy) begin
				cmd_o.advance = 1'b1;
				state_d       = ST_EMIT;
				idx_d         = '0;
			end
		end
	end

	assign req_stall = !take_ok;

	// An accepted advance always opens a group at its first pixel.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_o.advance |=> (state_q == ST_EMIT && idx_q == '0))
		else $error("group did not start at pixel zero");

	// The pixel index only moves when a pixel is handed on.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && !cmd_o.emit) |=> $stable(idx_q))
		else $error("pixel index moved without an emit");

	// Start and advance never come together.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd_o.start && cmd_o.advance))
		else $error("start and advance at once");

endmodule

`default_nettype wire

/* rtl/cpg_dp.sv */
`default_nettype none

module cpg_dp #(
	parameter int COORD_BITS = cpg_pkg::CP_COORD_BITS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cpg_pkg::cpg_in_t  req_data,
	input  wire cpg_pkg::cpg_cmd_t cmd_i,
	output cpg_pkg::cpg_sts_t      sts_o,
	output logic                   px_valid,
	input  wire logic              px_stall,
	output cpg_pkg::cpg_out_t      px_data
);
	import cpg_pkg::*;

	localparam int CB = COORD_BITS;

	// Circle registers loaded by a start item.
	logic [CB-1:0]      centre_col_q, centre_row_q;
	logic [FIELD_W-1:0] draw_colour_q;
	logic               fill_on_q;
	logic               busy_q;

	// Walk registers.
	logic [CB-1:0]    step_x_q, step_y_q, inner_y_q;
	logic [DEC_W-1:0] decision_q;

	// Snapshot of the group being emitted.
	logic [CB-1:0] grp_a_q, grp_b_q;
	logic          grp_done_q;

	// Output register.
	logic     out_valid_q;
	cpg_out_t out_q;

	// Walk step combinational terms.
	logic [CB:0]        x_new;
	logic signed [CB+1:0] y_new;
	logic               go_se;
	logic               walk_done;
	logic               inner_step;
	logic [DEC_W-1:0]   dec_next;
	logic [DEC_W-1:0]   dec_start;
	logic [CB-1:0]      radius;

	// Pixel forming terms.
	logic [CB-1:0] col_off, row_off, pix_col, pix_row;

	assign radius     = req_data.radius[CB-1:0];
	assign dec_start  = DEC_W'(DEC_START) - (DEC_W'(radius) << 1);
	assign inner_step = fill_on_q && (inner_y_q < step_y_q);

	// One midpoint step: east when the decision is negative, else south-east.
	always_comb begin
		go_se = !decision_q[DEC_W-1];
		x_new = {1'b0, step_x_q} + 1'b1;
		y_new = $signed({2'b00, step_y_q}) - $signed((CB+2)'(go_se));
		if (go_se) begin
			dec_next = decision_q + ((DEC_W'(step_x_q) - DEC_W'(step_y_q)) << 2)
				+ DEC_W'(DEC_INC_SE);
		end else begin
			dec_next = decision_q + (DEC_W'(step_x_q) << 2) + DEC_W'(DEC_INC_E);
		end
		walk_done = $signed({1'b0, x_new}) > y_new;
	end

	// Circle and walk state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (cmd_i.start) begin
			busy_q <= 1'b1;
		end else if (cmd_i.advance && !inner_step && walk_done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.start) begin
			centre_col_q  <= req_data.centre_x[CB-1:0];
			centre_row_q  <= req_data.centre_y[CB-1:0];
			draw_colour_q <= req_data.pixel_colour;
			fill_on_q     <= req_data.fill;
			step_x_q      <= '0;
			step_y_q      <= radius;
			inner_y_q     <= '0;
			decision_q    <= dec_start;
		end else if (cmd_i.advance) begin
			grp_a_q <= step_x_q;
			grp_b_q <= fill_on_q ? inner_y_q : step_y_q;
			if (inner_step) begin
				inner_y_q  <= inner_y_q + 1'b1;
				grp_done_q <= 1'b0;
			end else begin
				decision_q <= dec_next;
				step_x_q   <= x_new[CB-1:0];
				step_y_q   <= y_new[CB-1:0];
				inner_y_q  <= x_new[CB-1:0];
				grp_done_q <= walk_done;
			end
		end
	end

	// Mirror the pair: upper half swaps the roles, bit 0 and bit 1 negate.
	always_comb begin
		col_off = cmd_i.pix_idx[2] ? grp_b_q : grp_a_q;
		row_off = cmd_i.pix_idx[2] ? grp_a_q : grp_b_q;
		pix_col = cmd_i.pix_idx[0] ? centre_col_q - col_off : centre_col_q + col_off;
		pix_row = cmd_i.pix_idx[1] ? centre_row_q - row_off : centre_row_q + row_off;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd_i.emit) begin
			out_valid_q <= 1'b1;
		end else if (!px_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.emit) begin
			out_q.out_x       <= FIELD_W'(pix_col);
			out_q.out_y       <= FIELD_W'(pix_row);
			out_q.out_colour  <= draw_colour_q;
			out_q.group_last  <= (cmd_i.pix_idx == IDX_LAST);
			out_q.circle_done <= (cmd_i.pix_idx == IDX_LAST) && grp_done_q;
		end
	end

	assign px_valid       = out_valid_q;
	assign px_data        = out_q;
	assign sts_o.busy     = busy_q;
	assign sts_o.out_room = !out_valid_q || !px_stall;

	// The walk never passes the diagonal while a circle is active.
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (step_x_q <= step_y_q))
		else $error("walk passed the diagonal while busy");

	// The fill row never runs past the outline row.
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (inner_y_q <= step_y_q))
		else $error("fill row past outline row");

	// Completion is flagged only on the last pixel of a group.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.circle_done) |-> out_q.group_last)
		else $error("circle done off the group boundary");

endmodule

`default_nettype wire

/* rtl/circle_point_generator_top.sv */
// Channel  Direction  Payload    Handshake
// req      in         cpg_in_t   req_valid / req_stall
// px       out        cpg_out_t  px_valid / px_stall
//
// A start item, or an advance item while idle, gives no pixel.
// An advance item while a circle is active gives eight pixels, one a cycle
// from the output register while px does not stall.
// The next item is taken in the cycle that loads the eighth pixel.
// Stalls on px hold the pixel sequencer; req_stall stays high meanwhile.
// Reset clears the controller state, the active flag and the output valid.
`default_nettype none

module circle_point_generator_top #(
	parameter int COORD_BITS = cpg_pkg::CP_COORD_BITS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_stall,
	input  wire cpg_pkg::cpg_in_t req_data,
	output logic                  px_valid,
	input  wire logic             px_stall,
	output cpg_pkg::cpg_out_t     px_data
);
	import cpg_pkg::*;

	cpg_cmd_t cmd;
	cpg_sts_t sts;

	cpg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_op    (req_data.opcode),
		.req_stall (req_stall),
		.sts_i     (sts),
		.cmd_o     (cmd)
	);

	cpg_dp #(
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_data (req_data),
		.cmd_i    (cmd),
		.sts_o    (sts),
		.px_valid (px_valid),
		.px_stall (px_stall),
		.px_data  (px_data)
	);

endmodule

`default_nettype wire

/* sim/tb_circle_point_generator_top.sv */
`timescale 1ns / 100ps

module tb_circle_point_generator_top;
	import cpg_pkg::*;

	localparam int RAND_ITEMS  = 320;
	localparam int CALM_FROM   = 120;
	localparam int CALM_TO     = 190;
	localparam int PAUSE_AT    = 240;
	localparam int HOLD_AFTER  = 600;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 24;
	localparam int CYCLE_LIMIT = 100000;
	localparam int PRINT_CAP   = 60;

	// One row of the directed table; typed rows carry the group they must give.
	typedef struct {
		cpg_in_t            item;
		bit                 typed;
		int unsigned        n_px;
		logic [FIELD_W-1:0] ex_x;
		logic [FIELD_W-1:0] ex_y;
		logic [FIELD_W-1:0] ex_col;
		bit                 ex_done;
	} dir_row_t;

	logic     clk;
	logic     arst_n;
	logic     req_valid;
	logic     req_stall;
	cpg_in_t  req_data;
	logic     px_valid;
	logic     px_stall;
	cpg_out_t px_data;

	// Pixels still owed by the block, oldest first.
	cpg_out_t pixel_expect_q[$];
	// Group worked out for the item just accepted, and a hand-typed override.
	cpg_out_t next_group[$];
	cpg_out_t typed_px[$];
	bit       typed_on;

	int  fail_count;
	int  cycle_count;
	int  px_seen;
	int  live_items;
	bit  calm;
	bit  drained;

	// Rasterizer state as the testbench tracks it.
	logic [FIELD_W-1:0]      ctr_col;
	logic [FIELD_W-1:0]      ctr_row;
	logic [FIELD_W-1:0]      colour_q;
	logic                    fill_mode;
	logic [FIELD_W-1:0]      walk_x;
	logic [FIELD_W-1:0]      walk_y;
	logic [FIELD_W-1:0]      span_y;
	logic signed [DEC_W-1:0] walk_dec;
	bit                      walking;

	circle_point_generator_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data (req_data),
		.px_valid (px_valid),
		.px_stall (px_stall),
		.px_data  (px_data)
	);

	// Free-running clock, 20 ns period.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Run guard: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d pixels pending", cycle_count,
				pixel_expect_q.size());
			$display("tb_circle_point_generator_top NOT OK");
			$finish;
		end
	end

	// Prints one line per mismatch, up to a cap, and counts every one.
	task automatic flag_error(input string msg);
		fail_count++;
		if (fail_count <= PRINT_CAP)
			$display("ERROR cycle %0d: %s", cycle_count, msg);
	endtask

	function automatic cpg_in_t req_item(input logic op, input logic [FIELD_W-1:0] cx,
		input logic [FIELD_W-1:0] cy, input logic [FIELD_W-1:0] r,
		input logic [FIELD_W-1:0] col, input logic fl);
		cpg_in_t it;
		it.opcode       = op;
		it.centre_x     = cx;
		it.centre_y     = cy;
		it.radius       = r;
		it.pixel_colour = col;
		it.fill         = fl;
		return it;
	endfunction

	function automatic dir_row_t row(input cpg_in_t it, input bit typed,
		input int unsigned n, input logic [FIELD_W-1:0] x, input logic [FIELD_W-1:0] y,
		input logic [FIELD_W-1:0] col, input bit dn);
		dir_row_t d;
		d.item    = it;
		d.typed   = typed;
		d.n_px    = n;
		d.ex_x    = x;
		d.ex_y    = y;
		d.ex_col  = col;
		d.ex_done = dn;
		return d;
	endfunction

	// Midpoint circle walk: updates the tracked state for one accepted item and
	// leaves the eight mirrored pixels of an advance in next_group.
	task automatic rasterize_item(input cpg_in_t it);
		logic [FIELD_W-1:0] a, b, cx, cy;
		logic [FIELD_W-1:0] px[GROUP_PIX];
		logic [FIELD_W-1:0] py[GROUP_PIX];
		int                 xi, yi, pi;
		bit                 fin;
		cpg_out_t           pix;
		next_group.delete();
		if (it.opcode == OP_START) begin
			ctr_col   = it.centre_x;
			ctr_row   = it.centre_y;
			colour_q  = it.pixel_colour;
			fill_mode = it.fill;
			walk_x    = '0;
			walk_y    = it.radius;
			span_y    = '0;
			walk_dec  = DEC_W'(DEC_START - 2 * int'(it.radius));
			walking   = 1'b1;
		end else if (walking) begin
			a   = walk_x;
			b   = fill_mode ? span_y : walk_y;
			cx  = ctr_col;
			cy  = ctr_row;
			fin = 1'b0;
			// In fill mode the inner row climbs to y before the walk moves on.
			if (fill_mode && span_y < walk_y) begin
				span_y = span_y + 1'b1;
			end else begin
				xi = int'(walk_x);
				yi = int'(walk_y);
				pi = int'(walk_dec);
				if (pi < 0) begin
					pi = pi + 4 * xi + DEC_INC_E;
				end else begin
					pi = pi + 4 * (xi - yi) + DEC_INC_SE;
					yi = yi - 1;
				end
				xi       = xi + 1;
				walk_dec = DEC_W'(pi);
				walk_x   = xi[FIELD_W-1:0];
				walk_y   = yi[FIELD_W-1:0];
				fin      = (xi > yi);
				span_y   = walk_x;
				if (fin)
					walking = 1'b0;
			end
			px = '{cx + a, cx - a, cx + a, cx - a, cx + b, cx - b, cx + b, cx - b};
			py = '{cy + b, cy + b, cy - b, cy - b, cy + a, cy + a, cy - a, cy - a};
			for (int k = 0; k < GROUP_PIX; k++) begin
				pix.out_x       = px[k];
				pix.out_y       = py[k];
				pix.out_colour  = colour_q;
				pix.group_last  = (k == GROUP_PIX - 1);
				pix.circle_done = (k == GROUP_PIX - 1) && fin;
				next_group.push_back(pix);
			end
		end
	endtask

	// Offers one item from a falling edge, waits for it to be taken, and books
	// the pixels it owes. Returns on the falling edge after acceptance.
	task automatic offer(input cpg_in_t it);
		while (!calm && $urandom_range(99) < 16) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req_data  = it;
		req_valid = 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		rasterize_item(it);
		if (typed_on) begin
			foreach (typed_px[k])
				pixel_expect_q.push_back(typed_px[k]);
		end else begin
			foreach (next_group[k])
				pixel_expect_q.push_back(next_group[k]);
		end
		@(negedge clk);
	endtask

	// Counts an item that does work, opens the quiet window, and once lets the
	// block drain completely before going on.
	task automatic pace();
		live_items++;
		calm = (live_items >= CALM_FROM && live_items < CALM_TO);
		if (!drained && live_items >= PAUSE_AT) begin
			drained   = 1'b1;
			req_valid = 1'b0;
			while (pixel_expect_q.size() != 0)
				@(negedge clk);
		end
	endtask

	// Pixel checker: every accepted pixel against the oldest one owed.
	always @(posedge clk) begin : px_check
		cpg_out_t want;
		if (arst_n && px_valid && !px_stall) begin
			px_seen++;
			if (pixel_expect_q.size() == 0) begin
				flag_error($sformatf("pixel %h with none pending", px_data));
			end else begin
				want = pixel_expect_q.pop_front();
				if (px_data.out_x !== want.out_x)
					flag_error($sformatf("out_x %h, want %h", px_data.out_x, want.out_x));
				if (px_data.out_y !== want.out_y)
					flag_error($sformatf("out_y %h, want %h", px_data.out_y, want.out_y));
				if (px_data.out_colour !== want.out_colour)
					flag_error($sformatf("out_colour %h, want %h", px_data.out_colour,
						want.out_colour));
				if (px_data.group_last !== want.group_last)
					flag_error($sformatf("group_last %b, want %b", px_data.group_last,
						want.group_last));
				if (px_data.circle_done !== want.circle_done)
					flag_error($sformatf("circle_done %b, want %b", px_data.circle_done,
						want.circle_done));
			end
		end
	end

	// Pixel receiver: random stalls, a quiet window, and one long hold-off
	// that backs the block up into its input.
	initial begin : px_receiver
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		px_stall  = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && px_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				px_stall = 1'b1;
				hold_left--;
			end else if (calm) begin
				px_stall = 1'b0;
			end else begin
				px_stall = ($urandom_range(99) < 16);
			end
		end
	end

	// Stimulus: directed table first, then random circles.
	initial begin : stimulus
		dir_row_t           dir_tab[$];
		cpg_out_t           pix;
		cpg_in_t            it;
		logic [FIELD_W-1:0] r;
		logic               fl;
		bit                 big;
		int                 n_adv;

		arst_n      = 1'b0;
		req_valid   = 1'b0;
		req_data    = '0;
		typed_on    = 1'b0;
		fail_count  = 0;
		cycle_count = 0;
		px_seen     = 0;
		live_items  = 0;
		calm        = 1'b0;
		drained     = 1'b0;
		ctr_col     = '0;
		ctr_row     = '0;
		colour_q    = '0;
		fill_mode   = 1'b0;
		walk_x      = '0;
		walk_y      = '0;
		span_y      = '0;
		walk_dec    = '0;
		walking     = 1'b0;

		// Advance while idle after reset, then zero radius in both modes.
		dir_tab.push_back(row(req_item(OP_ADVANCE, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
			1'b0), 1, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(req_item(OP_START, 16'h1234, 16'h5678, 16'h0000, 16'hF800,
			1'b0), 1, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(req_item(OP_ADVANCE, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
			1'b1), 1, GROUP_PIX, 16'h1234, 16'h5678, 16'hF800, 1));
		dir_tab.push_back(row(req_item(OP_ADVANCE, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			1'b0), 1, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(req_item(OP_START, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF,
			1'b1), 1, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(req_item(OP_ADVANCE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			1'b1), 1, GROUP_PIX, 16'h0000, 16'h0000, 16'hFFFF, 1));
		// Outline radius 5 at the top corner: coordinates wrap past the edge.
		dir_tab.push_back(row(req_item(OP_START, 16'hFFFF, 16'hFFFF, 16'h0005, 16'h07E0,
			1'b0), 1, 0, 0, 0, 0, 0));
		repeat (4)
			dir_tab.push_back(row(req_item(OP_ADVANCE, 16'h0000, 16'h0000, 16'h0000,
				16'h0000, 1'b0), 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(req_item(OP_ADVANCE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			1'b1), 1, 0, 0, 0, 0, 0));
		// Largest radius in fill mode: the first group sits on the centre.
		dir_tab.push_back(row(req_item(OP_START, 16'h0008, 16'h0003, 16'hFFFF, 16'h001F,
			1'b1), 1, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(req_item(OP_ADVANCE, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			1'b0), 1, GROUP_PIX, 16'h0008, 16'h0003, 16'h001F, 0));
		dir_tab.push_back(row(req_item(OP_ADVANCE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			1'b0), 0, 0, 0, 0, 0, 0));
		// Restart in the middle of a walk, largest radius in outline mode.
		dir_tab.push_back(row(req_item(OP_START, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h5555,
			1'b0), 1, 0, 0, 0, 0, 0));
		repeat (2)
			dir_tab.push_back(row(req_item(OP_ADVANCE, 16'h0000, 16'hFFFF, 16'h0000,
				16'hFFFF, 1'b1), 0, 0, 0, 0, 0, 0));
		// Small filled disc walked to the end, then one advance too many.
		dir_tab.push_back(row(req_item(OP_START, 16'd100, 16'd200, 16'h0002, 16'hAAAA,
			1'b1), 1, 0, 0, 0, 0, 0));
		repeat (5)
			dir_tab.push_back(row(req_item(OP_ADVANCE, 16'h0000, 16'h0000, 16'h0000,
				16'h0000, 1'b0), 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(req_item(OP_ADVANCE, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			1'b0), 1, 0, 0, 0, 0, 0));

		// Hold reset, then release it at a falling edge.
		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: typed rows give their own group, the rest are predicted.
		foreach (dir_tab[i]) begin
			typed_on = dir_tab[i].typed;
			typed_px.delete();
			for (int k = 0; k < dir_tab[i].n_px; k++) begin
				pix.out_x       = dir_tab[i].ex_x;
				pix.out_y       = dir_tab[i].ex_y;
				pix.out_colour  = dir_tab[i].ex_col;
				pix.group_last  = (k == GROUP_PIX - 1);
				pix.circle_done = (k == GROUP_PIX - 1) && dir_tab[i].ex_done;
				typed_px.push_back(pix);
			end
			offer(dir_tab[i].item);
		end
		typed_on = 1'b0;

		// Random part: mostly whole circles with small radii, some cut short,
		// some huge radii walked a few steps, and stray advances while idle.
		while (live_items < RAND_ITEMS) begin
			big = ($urandom_range(7) == 0);
			fl  = $urandom_range(1);
			if (big)
				r = 16'($urandom);
			else if (fl)
				r = 16'($urandom_range(6));
			else
				r = 16'($urandom_range(24));
			it = req_item(OP_START, 16'($urandom), 16'($urandom), r, 16'($urandom), fl);
			offer(it);
			pace();
			if (big)
				n_adv = $urandom_range(1, 4);
			else if ($urandom_range(9) == 0)
				n_adv = $urandom_range(1, 6);
			else
				n_adv = 1 << 20;
			while (walking && n_adv > 0) begin
				offer(req_item(OP_ADVANCE, 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 1'($urandom)));
				pace();
				n_adv--;
			end
			if (!walking && $urandom_range(3) == 0)
				offer(req_item(OP_ADVANCE, 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 1'($urandom)));
		end

		// Let every owed pixel arrive, then watch a little longer for extras.
		req_valid = 1'b0;
		calm      = 1'b0;
		while (pixel_expect_q.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES)
			@(negedge clk);
		if (fail_count == 0)
			$display("tb_circle_point_generator_top OK");
		else
			$display("tb_circle_point_generator_top NOT OK");
		$finish;
	end

endmodule

/* files.f */
rtl/cpg_pkg.sv
rtl/cpg_ctrl.sv
rtl/cpg_dp.sv
rtl/circle_point_generator_top.sv
sim/tb_circle_point_generator_top.sv
